// ===== rtl/mcm_pkg.sv =====
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared types, codes and bank math for the multicart bank and IRQ mapper.
// ----------------------------------------------------------------------------
package mcm_pkg;

	// input operation codes
	typedef enum logic [1:0] {
		OP_RESTART = 2'd0,
		OP_LOW     = 2'd1,
		OP_HIGH    = 2'd2,
		OP_TICK    = 2'd3
	} opcode_t;

	// result kinds
	localparam logic [1:0] KIND_PRG    = 2'd0;
	localparam logic [1:0] KIND_CHR    = 2'd1;
	localparam logic [1:0] KIND_MIRROR = 2'd2;
	localparam logic [1:0] KIND_IRQ    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_PATCH_MODE = 2'd0;
	localparam logic [1:0] CFG_PRG_BANKS  = 2'd1;
	localparam logic [1:0] CFG_CHR_ROM    = 2'd2;

	localparam logic [1:0] PATCH_EIGHT = 2'd1;
	localparam logic [1:0] PATCH_IRQ   = 2'd2;

	// decoded high-region addresses
	localparam logic [15:0] HI_MASK      = 16'hE001;
	localparam logic [15:0] HI_BANK_SEL  = 16'h8000;
	localparam logic [15:0] HI_BANK_DATA = 16'h8001;
	localparam logic [15:0] HI_MIRROR    = 16'hA000;
	localparam logic [15:0] HI_IRQ_LATCH = 16'hC000;
	localparam logic [15:0] HI_IRQ_RELD  = 16'hC001;
	localparam logic [15:0] HI_IRQ_OFF   = 16'hE000;
	localparam logic [15:0] HI_IRQ_ON    = 16'hE001;

	localparam logic [7:0] PRG_MASK   = 8'h3F;
	localparam logic [7:0] BASE_EIGHT = 8'hC0;
	localparam logic [7:0] OFF_EIGHT  = 8'h30;
	localparam logic [7:0] OFF_NORMAL = 8'h10;
	localparam logic [7:0] IRQ_ODD_A  = 8'h29;
	localparam logic [7:0] IRQ_ODD_B  = 8'h70;
	localparam logic [7:0] IRQ_FIXED  = 8'h07;
	localparam logic [7:0] BANK_LAST2 = 8'd62;
	localparam logic [7:0] BANK_LAST1 = 8'd63;

	// where a program step takes its bank from
	typedef enum logic [1:0] {
		SRC_REGS    = 2'd0,
		SRC_APPLIED = 2'd1,
		SRC_DATA    = 2'd2,
		SRC_DIRECT  = 2'd3
	} prg_src_t;

	typedef enum logic [1:0] {
		CHR_NONE   = 2'd0,
		CHR_APPLY  = 2'd1,
		CHR_DIRECT = 2'd2
	} chr_job_t;

	typedef enum logic [1:0] {
		PH_PRG = 2'd0,
		PH_CHR = 2'd1,
		PH_ONE = 2'd2
	} phase_t;

	// work list of one input word
	typedef struct packed {
		logic [2:0] prg_n;
		logic [1:0] prg_start;
		prg_src_t   prg_src;
		chr_job_t   chr_job;
		logic       one;
		logic [1:0] one_kind;
		logic       one_val;
	} plan_t;

	// one emission step from the controller
	typedef struct packed {
		logic       emit;
		phase_t     phase;
		logic [2:0] idx;
		logic       last;
		prg_src_t   prg_src;
		chr_job_t   chr_job;
		logic [1:0] one_kind;
		logic       one_val;
	} step_t;

	function automatic logic [7:0] chr_mask(input logic [3:0] sel);
		logic [7:0] m;
		case (sel)
			4'd8:    m = 8'h01;
			4'd9:    m = 8'h03;
			4'd10:   m = 8'h07;
			4'd11:   m = 8'h0F;
			4'd12:   m = 8'h1F;
			4'd13:   m = 8'h3F;
			4'd14:   m = 8'h7F;
			4'd15:   m = 8'hFF;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/multicart_bank_and_scanline_irq_mapper.sv =====
// ----------------------------------------------------------------------------
// multicart_bank_and_scanline_irq_mapper
// MMC3-style multicart mapper: CPU writes and scanline ticks in, bank
// mapping updates out.
// ----------------------------------------------------------------------------
// channel  | direction | handshake        | contents
// s_*      | in        | s_tvalid/tready  | CPU write, restart or tick word
// m_*      | out       | m_tvalid/tready  | bank / mirroring / irq update
// cfg_*    | in        | cfg_valid/ready  | patch mode, bank count, chr rom
//
// An input word is taken, then its updates leave one per cycle from the
// output register: up to twelve for restart or a low-region write. The
// sequencer walks one result list at a time. Output stalls hold the
// sequencer; a new word is taken once the last update of the previous
// one sits in the output register. Reset is asynchronous and sets the
// mapper to its power-on banks.
module multicart_bank_and_scanline_irq_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // address[15:0], write_data[23:16], rendering_visible[24]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // slot[2:0], value[12:3]
	output logic [1:0]  m_tuser,   // update_kind[1:0]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	import mcm_pkg::*;

	plan_t      plan;
	step_t      step;
	logic       out_free;
	logic       in_fire;
	logic [2:0] slot;
	logic [9:0] value;

	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid && s_tready;
	assign m_tdata   = {3'b000, value, slot};

	mcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.plan     (plan),
		.out_free (out_free),
		.in_ready (s_tready),
		.step     (step)
	);

	mcm_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_fire          (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_fire           (in_fire),
		.opcode            (opcode_t'(s_tuser)),
		.address           (s_tdata[15:0]),
		.write_data        (s_tdata[23:16]),
		.rendering_visible (s_tdata[24]),
		.step              (step),
		.out_ready         (m_tready),
		.plan              (plan),
		.out_free          (out_free),
		.out_valid         (m_tvalid),
		.out_kind          (m_tuser),
		.out_slot          (slot),
		.out_value         (value),
		.out_last          (m_tlast)
	);

endmodule

// ===== rtl/mcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcm_ctrl
// Sequencer: takes the work list of an input word and steps out one
// result per cycle whenever the output register is free.
// ----------------------------------------------------------------------------
module mcm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  mcm_pkg::plan_t plan,
	input  logic           out_free,
	output logic           in_ready,
	output mcm_pkg::step_t step
);
	import mcm_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_PRG, ST_CHR, ST_ONE} state_t;

	state_t     state_q;
	plan_t      plan_q;
	logic [2:0] cnt_q;
	logic       go;
	logic       prg_end;

	assign in_ready = (state_q == ST_IDLE);
	assign go       = out_free && (state_q != ST_IDLE);
	assign prg_end  = (cnt_q == plan_q.prg_n - 3'd1);

	// step command
	always_comb begin
		step          = '0;
		step.emit     = go;
		step.prg_src  = plan_q.prg_src;
		step.chr_job  = plan_q.chr_job;
		step.one_kind = plan_q.one_kind;
		step.one_val  = plan_q.one_val;
		case (state_q)
			ST_PRG: begin
				step.phase = PH_PRG;
				step.idx   = {1'b0, plan_q.prg_start + cnt_q[1:0]};
				step.last  = prg_end && (plan_q.chr_job == CHR_NONE);
			end
			ST_CHR: begin
				step.phase = PH_CHR;
				step.idx   = cnt_q;
				step.last  = (cnt_q == 3'd7);
			end
			ST_ONE: begin
				step.phase = PH_ONE;
				step.last  = 1'b1;
			end
			default: step.phase = PH_ONE;
		endcase
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			plan_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						plan_q <= plan;
						cnt_q  <= '0;
						if (plan.prg_n != 3'd0)          state_q <= ST_PRG;
						else if (plan.chr_job != CHR_NONE) state_q <= ST_CHR;
						else if (plan.one)               state_q <= ST_ONE;
					end
				end
				ST_PRG: begin
					if (go) begin
						if (prg_end) begin
							cnt_q   <= '0;
							state_q <= (plan_q.chr_job != CHR_NONE) ? ST_CHR : ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
				end
				ST_CHR: begin
					if (go) begin
						cnt_q <= cnt_q + 3'd1;
						if (cnt_q == 3'd7) state_q <= ST_IDLE;
					end
				end
				ST_ONE: begin
					if (go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/mcm_datapath.sv =====
// ----------------------------------------------------------------------------
// mcm_datapath
// Mapper registers, IRQ counter, work-list decode, bank math and the
// output register.
// ----------------------------------------------------------------------------
module mcm_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_fire,
	input  logic [1:0]       cfg_index,
	input  logic [8:0]       cfg_data,
	input  logic             in_fire,
	input  mcm_pkg::opcode_t opcode,
	input  logic [15:0]      address,
	input  logic [7:0]       write_data,
	input  logic             rendering_visible,
	input  mcm_pkg::step_t   step,
	input  logic             out_ready,
	output mcm_pkg::plan_t   plan,
	output logic             out_free,
	output logic             out_valid,
	output logic [1:0]       out_kind,
	output logic [2:0]       out_slot,
	output logic [9:0]       out_value,
	output logic             out_last
);
	import mcm_pkg::*;

	// configuration
	logic [1:0] patch_q;
	logic [8:0] banks_q;
	logic       chr_rom_q;

	// mapper state
	logic [7:0] outer_q [4];
	logic [1:0] outer_idx_q;
	logic [7:0] bank_sel_q;
	logic [7:0] prg_q [4];
	logic [7:0] aprg_q [4];
	logic [7:0] chr_q [8];
	logic [9:0] achr_q [8];
	logic       irq_en_q;
	logic [7:0] irq_cnt_q;
	logic [7:0] irq_rel_q;
	logic       rel_pend_q;
	logic       cleared_q;
	logic [7:0] data_q;

	logic [15:0] hi_addr;
	logic [7:0]  irq_data;
	logic [7:0]  init_prg2, init_prg3;
	logic [8:0]  banks_m2, banks_m1;
	logic [1:0]  page;
	logic [7:0]  prg_bank, prg_val;
	logic [2:0]  chr_j;
	logic [7:0]  base, off8;
	logic [9:0]  chr_val;
	logic [9:0]  val;

	logic       out_valid_q, out_last_q;
	logic [1:0] out_kind_q;
	logic [2:0] out_slot_q;
	logic [9:0] out_value_q;

	assign hi_addr   = address & HI_MASK;
	assign irq_data  = (patch_q == PATCH_IRQ && (write_data == IRQ_ODD_A ||
	                   write_data == IRQ_ODD_B)) ? IRQ_FIXED : write_data;
	assign banks_m2  = banks_q - 9'd2;
	assign banks_m1  = banks_q - 9'd1;
	assign init_prg2 = (patch_q == PATCH_EIGHT) ? BANK_LAST2 : banks_m2[7:0];
	assign init_prg3 = (patch_q == PATCH_EIGHT) ? BANK_LAST1 : banks_m1[7:0];

	// work list for the incoming word
	always_comb begin
		plan = '0;
		plan.prg_src = SRC_REGS;
		plan.chr_job = CHR_NONE;
		case (opcode)
			OP_RESTART: begin
				plan.prg_n   = 3'd4;
				plan.prg_src = SRC_DIRECT;
				plan.chr_job = CHR_DIRECT;
			end
			OP_LOW: begin
				if (!outer_q[3][6]) begin
					plan.prg_n   = 3'd4;
					plan.chr_job = CHR_APPLY;
				end
			end
			OP_HIGH: begin
				case (hi_addr)
					HI_BANK_SEL: begin
						plan.prg_src = SRC_APPLIED;
						if (write_data[6] != bank_sel_q[6]) plan.prg_n = 3'd2;
						if (chr_rom_q && write_data[7] != bank_sel_q[7])
							plan.chr_job = CHR_DIRECT;
					end
					HI_BANK_DATA: begin
						plan.prg_src = SRC_DATA;
						case (bank_sel_q[2:0])
							3'd6: begin
								plan.prg_n     = 3'd1;
								plan.prg_start = bank_sel_q[6] ? 2'd2 : 2'd0;
							end
							3'd7: begin
								plan.prg_n     = 3'd1;
								plan.prg_start = 2'd1;
							end
							default: plan.chr_job = CHR_APPLY;
						endcase
					end
					HI_MIRROR: begin
						plan.one      = 1'b1;
						plan.one_kind = KIND_MIRROR;
						plan.one_val  = write_data[0];
					end
					HI_IRQ_OFF: begin
						plan.one      = 1'b1;
						plan.one_kind = KIND_IRQ;
					end
					default: plan.one = 1'b0;
				endcase
			end
			OP_TICK: begin
				plan.one      = rendering_visible && irq_cnt_q == 8'd1 && irq_en_q;
				plan.one_kind = KIND_IRQ;
				plan.one_val  = 1'b1;
			end
			default: plan.one = 1'b0;
		endcase
	end

	// program bank math
	assign page = step.idx[1:0];
	always_comb begin
		case (step.prg_src)
			SRC_REGS:    prg_bank = prg_q[page];
			SRC_APPLIED: prg_bank = aprg_q[page];
			SRC_DATA:    prg_bank = data_q;
			default:     prg_bank = aprg_q[page];
		endcase
	end
	assign prg_val = ((prg_bank & ~{2'b00, outer_q[3][5:0]}) & PRG_MASK) | outer_q[1];

	// character bank math
	assign chr_j   = step.idx ^ {bank_sel_q[7], 2'b00};
	assign base    = outer_q[0] & ((patch_q == PATCH_EIGHT) ? BASE_EIGHT : 8'hFF);
	assign off8    = outer_q[2] & ((patch_q == PATCH_EIGHT) ? OFF_EIGHT : OFF_NORMAL);
	assign chr_val = {2'b00, (chr_q[chr_j] & chr_mask(outer_q[2][3:0])) | base}
	                 + {off8[5:0], 4'b0000};

	always_comb begin
		case (step.phase)
			PH_PRG:  val = (step.prg_src == SRC_DIRECT) ? {2'b00, aprg_q[page]}
			                                            : {2'b00, prg_val};
			PH_CHR:  val = (step.chr_job == CHR_DIRECT) ? achr_q[step.idx] : chr_val;
			default: val = {9'd0, step.one_val};
		endcase
	end

	// configuration and mapper state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patch_q     <= '0;
			banks_q     <= 9'd64;
			chr_rom_q   <= 1'b1;
			outer_idx_q <= '0;
			bank_sel_q  <= '0;
			irq_en_q    <= 1'b0;
			irq_cnt_q   <= '0;
			irq_rel_q   <= '0;
			rel_pend_q  <= 1'b0;
			cleared_q   <= 1'b0;
			data_q      <= '0;
			for (int i = 0; i < 4; i++) begin
				outer_q[i] <= '0;
				prg_q[i]   <= (i == 2) ? BANK_LAST2 : (i == 3) ? BANK_LAST1 : 8'(i);
				aprg_q[i]  <= (i == 2) ? BANK_LAST2 : (i == 3) ? BANK_LAST1 : 8'(i);
			end
			for (int i = 0; i < 8; i++) begin
				chr_q[i]  <= 8'(i);
				achr_q[i] <= 10'(i);
			end
		end else begin
			if (cfg_fire) begin
				case (cfg_index)
					CFG_PATCH_MODE: patch_q   <= cfg_data[1:0];
					CFG_PRG_BANKS:  banks_q   <= cfg_data;
					CFG_CHR_ROM:    chr_rom_q <= cfg_data[0];
					default:        ;
				endcase
			end
			if (in_fire) begin
				data_q <= write_data;
				case (opcode)
					OP_RESTART: begin
						outer_idx_q <= '0;
						bank_sel_q  <= '0;
						irq_en_q    <= 1'b0;
						irq_cnt_q   <= '0;
						irq_rel_q   <= '0;
						rel_pend_q  <= 1'b0;
						cleared_q   <= 1'b0;
						for (int i = 0; i < 4; i++) outer_q[i] <= '0;
						prg_q[0]  <= 8'd0;
						prg_q[1]  <= 8'd1;
						prg_q[2]  <= init_prg2;
						prg_q[3]  <= init_prg3;
						aprg_q[0] <= 8'd0;
						aprg_q[1] <= 8'd1;
						aprg_q[2] <= init_prg2;
						aprg_q[3] <= init_prg3;
						for (int i = 0; i < 8; i++) begin
							chr_q[i]  <= 8'(i);
							achr_q[i] <= 10'(i);
						end
					end
					OP_LOW: begin
						if (!outer_q[3][6]) begin
							outer_q[outer_idx_q] <= write_data;
							outer_idx_q          <= outer_idx_q + 2'd1;
						end
					end
					OP_HIGH: begin
						case (hi_addr)
							HI_BANK_SEL: begin
								if (write_data[6] != bank_sel_q[6]) begin
									prg_q[0]  <= prg_q[2];
									prg_q[2]  <= prg_q[0];
									aprg_q[0] <= aprg_q[2];
									aprg_q[2] <= aprg_q[0];
								end
								if (chr_rom_q && write_data[7] != bank_sel_q[7]) begin
									for (int i = 0; i < 4; i++) begin
										chr_q[i]      <= chr_q[i + 4];
										chr_q[i + 4]  <= chr_q[i];
										achr_q[i]     <= achr_q[i + 4];
										achr_q[i + 4] <= achr_q[i];
									end
								end
								bank_sel_q <= write_data;
							end
							HI_BANK_DATA: begin
								case (bank_sel_q[2:0])
									3'd0: begin
										chr_q[0] <= {write_data[7:1], 1'b0};
										chr_q[1] <= {write_data[7:1], 1'b1};
									end
									3'd1: begin
										chr_q[2] <= {write_data[7:1], 1'b0};
										chr_q[3] <= {write_data[7:1], 1'b1};
									end
									3'd6: begin
										if (bank_sel_q[6]) prg_q[2] <= write_data & PRG_MASK;
										else               prg_q[0] <= write_data & PRG_MASK;
									end
									3'd7: prg_q[1] <= write_data & PRG_MASK;
									default: chr_q[bank_sel_q[2:0] + 3'd2] <= write_data;
								endcase
							end
							HI_IRQ_LATCH: begin
								irq_rel_q <= irq_data;
								if (cleared_q) begin
									irq_cnt_q  <= irq_data;
									rel_pend_q <= 1'b0;
								end else begin
									rel_pend_q <= 1'b1;
								end
							end
							HI_IRQ_RELD: irq_cnt_q <= irq_rel_q;
							HI_IRQ_OFF: begin
								irq_en_q  <= 1'b0;
								cleared_q <= 1'b1;
							end
							HI_IRQ_ON: begin
								irq_en_q <= 1'b1;
								if (rel_pend_q) irq_cnt_q <= irq_rel_q;
							end
							default: ;
						endcase
					end
					OP_TICK: begin
						cleared_q <= 1'b0;
						if (rendering_visible && irq_cnt_q != 8'd0)
							irq_cnt_q <= irq_cnt_q - 8'd1;
					end
					default: ;
				endcase
			end
			// applied banks follow the emitted steps
			if (step.emit) begin
				if (step.phase == PH_PRG && step.prg_src != SRC_DIRECT)
					aprg_q[page] <= prg_val;
				if (step.phase == PH_CHR && step.chr_job == CHR_APPLY)
					achr_q[chr_j] <= chr_val;
			end
		end
	end

	// output register
	assign out_free = !out_valid_q || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.emit) begin
			case (step.phase)
				PH_PRG:  out_kind_q <= KIND_PRG;
				PH_CHR:  out_kind_q <= KIND_CHR;
				default: out_kind_q <= step.one_kind;
			endcase
			out_slot_q  <= (step.phase == PH_ONE) ? 3'd0 : step.idx;
			out_value_q <= val;
			out_last_q  <= step.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_slot  = out_slot_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule

// ===== rtl/mcm_checker.sv =====
// ----------------------------------------------------------------------------
// mcm_checker
// Port-level checks on the mapper's update stream.
// ----------------------------------------------------------------------------
module mcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import mcm_pkg::*;

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("update dropped while stalled");

	// mirroring and irq updates carry slot zero and close their word
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_MIRROR || m_tuser == KIND_IRQ)
		|-> m_tdata[2:0] == 3'd0 && m_tlast)
		else $error("single update malformed");

	// program updates address pages 0-3 with 8-bit banks
	a_prg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PRG |-> !m_tdata[2] && m_tdata[12:11] == 2'b00)
		else $error("program update out of range");

	// a character update in slot 7 always ends its word
	a_chr_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_CHR && m_tdata[2:0] == 3'd7 |-> m_tlast)
		else $error("character run not closed");

endmodule

bind multicart_bank_and_scanline_irq_mapper mcm_checker u_mcm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multicart bank and scanline IRQ mapper. A
// behavioral mapper model predicts each update word; a scoreboard compares
// every output word in order, under random idling and back-pressure.
// ----------------------------------------------------------------------------
typedef struct packed {
	logic [1:0] kind;
	logic [2:0] slot;
	logic [9:0] value;
	logic       last;
} update_t;

// predicted update words and their comparison
class update_board;
	update_t pending[$];
	int      n_bad;
	int      n_seen;

	function void note(update_t u);
		pending.push_back(u);
	endfunction

	function void check(update_t got);
		update_t want;
		n_seen++;
		if (pending.size() == 0) begin
			n_bad++;
			if (n_bad <= 10)
				$display("ERROR: unexpected update kind=%0d slot=%0d value=%0d last=%0d",
					got.kind, got.slot, got.value, got.last);
			return;
		end
		want = pending.pop_front();
		if (want != got) begin
			n_bad++;
			if (n_bad <= 10)
				$display("ERROR: update exp k=%0d s=%0d v=%0d l=%0d got k=%0d s=%0d v=%0d l=%0d",
					want.kind, want.slot, want.value, want.last,
					got.kind, got.slot, got.value, got.last);
		end
	endfunction
endclass

module tb_top;
	import mcm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;

	multicart_bank_and_scanline_irq_mapper dut (.*);

	update_board board;
	int  cycles;
	int  n_words;
	int  hold_off;      // cycles the receiver still refuses
	bit  busy_out;      // receiver may stall at random
	bit  busy_in;       // sender may idle at random

	// mapper model state
	logic [1:0] m_patch;
	logic [8:0] m_banks;
	logic       m_chr_rom;
	logic [7:0] outer[4];
	logic [1:0] outer_ptr;
	logic [7:0] bsel;
	logic [7:0] prg[4];
	logic [7:0] prg_on[4];
	logic [7:0] chr[8];
	logic [9:0] chr_on[8];
	logic       irq_on;
	logic [7:0] irq_cnt;
	logic [7:0] irq_rel;
	logic       reload_req;
	logic       cleared;
	update_t    batch[$];

	initial clk = 0;
	always #10 clk = ~clk;

	function automatic logic [7:0] mask_of(logic [3:0] sel);
		return (sel < 8) ? 8'h00 : 8'((9'h1 << (sel - 7)) - 1);
	endfunction

	function void emit(logic [1:0] k, logic [2:0] s, logic [9:0] v);
		update_t u;
		u.kind = k; u.slot = s; u.value = v; u.last = 0;
		batch.push_back(u);
	endfunction

	function void map_prg(int page, logic [7:0] bank);
		logic [7:0] b;
		b = (bank & ~(outer[3] & PRG_MASK)) & PRG_MASK;
		b = b | outer[1];
		prg_on[page] = b;
		emit(KIND_PRG, 3'(page), {2'b0, b});
	endfunction

	function void map_chr();
		logic [7:0] base, m;
		logic [9:0] off;
		base = outer[0] & ((m_patch != PATCH_EIGHT) ? 8'hFF : BASE_EIGHT);
		off  = 10'(outer[2] & ((m_patch != PATCH_EIGHT) ? OFF_NORMAL : OFF_EIGHT)) << 4;
		m    = mask_of(outer[2][3:0]);
		for (int i = 0; i < 8; i++)
			chr_on[i] = 10'((chr[i] & m) | base) + off;
		for (int i = 0; i < 8; i++)
			emit(KIND_CHR, 3'(i), bsel[7] ? chr_on[i ^ 4] : chr_on[i]);
	endfunction

	function void power_on();
		for (int i = 0; i < 4; i++) outer[i] = 0;
		outer_ptr = 0; bsel = 0;
		prg[0] = 0; prg[1] = 1;
		prg[2] = 8'(m_banks - 2); prg[3] = 8'(m_banks - 1);
		if (m_patch == PATCH_EIGHT) begin
			prg[2] = BANK_LAST2; prg[3] = BANK_LAST1;
		end
		prg_on = prg;
		for (int i = 0; i < 8; i++) begin
			chr[i] = 8'(i); chr_on[i] = 10'(i);
		end
		irq_on = 0; irq_cnt = 0; irq_rel = 0; reload_req = 0; cleared = 0;
	endfunction

	function void cpu_high(logic [15:0] a, logic [7:0] d);
		logic [7:0] t;
		logic [9:0] t10;
		case (a & HI_MASK)
			HI_BANK_SEL: begin
				if (d[6] != bsel[6]) begin
					t = prg[0]; prg[0] = prg[2]; prg[2] = t;
					t = prg_on[0]; prg_on[0] = prg_on[2]; prg_on[2] = t;
					map_prg(0, prg_on[0]);
					map_prg(1, prg_on[1]);
				end
				if (m_chr_rom && d[7] != bsel[7]) begin
					for (int i = 0; i < 4; i++) begin
						t = chr[i]; chr[i] = chr[i+4]; chr[i+4] = t;
						t10 = chr_on[i]; chr_on[i] = chr_on[i+4]; chr_on[i+4] = t10;
					end
					for (int i = 0; i < 8; i++) emit(KIND_CHR, 3'(i), chr_on[i]);
				end
				bsel = d;
			end
			HI_BANK_DATA: begin
				case (bsel[2:0])
					3'd0, 3'd1: begin
						chr[2*bsel[2:0]]   = d & 8'hFE;
						chr[2*bsel[2:0]+1] = 8'((d & 8'hFE) + 1);
						map_chr();
					end
					3'd6: begin
						if (bsel[6]) begin
							prg[2] = d & PRG_MASK; map_prg(2, d);
						end else begin
							prg[0] = d & PRG_MASK; map_prg(0, d);
						end
					end
					3'd7: begin
						prg[1] = d & PRG_MASK; map_prg(1, d);
					end
					default: begin
						chr[bsel[2:0] + 2] = d;
						map_chr();
					end
				endcase
			end
			HI_MIRROR: emit(KIND_MIRROR, 3'd0, {9'b0, d[0]});
			HI_IRQ_LATCH: begin
				if (m_patch == PATCH_IRQ && (d == IRQ_ODD_A || d == IRQ_ODD_B)) d = IRQ_FIXED;
				irq_rel = d; reload_req = 1;
				if (cleared) begin
					irq_cnt = d; reload_req = 0;
				end
			end
			HI_IRQ_RELD: irq_cnt = irq_rel;
			HI_IRQ_OFF: begin
				irq_on = 0; cleared = 1;
				emit(KIND_IRQ, 3'd0, 10'd0);
			end
			HI_IRQ_ON: begin
				irq_on = 1;
				if (reload_req) irq_cnt = irq_rel;
			end
			default: ;
		endcase
	endfunction

	// expected updates of one accepted word
	function void predict_word(opcode_t op, logic [15:0] a, logic [7:0] d, logic vis);
		batch.delete();
		case (op)
			OP_RESTART: begin
				power_on();
				for (int i = 0; i < 4; i++) emit(KIND_PRG, 3'(i), {2'b0, prg[i]});
				for (int i = 0; i < 8; i++) emit(KIND_CHR, 3'(i), 10'(i));
			end
			OP_LOW: if (!outer[3][6]) begin
				outer[outer_ptr] = d;
				outer_ptr++;
				for (int i = 0; i < 4; i++) map_prg(i, prg[i]);
				map_chr();
			end
			OP_HIGH: cpu_high(a, d);
			default: begin
				cleared = 0;
				if (vis && irq_cnt != 0) begin
					irq_cnt--;
					if (irq_cnt == 0 && irq_on) emit(KIND_IRQ, 3'd0, 10'd1);
				end
			end
		endcase
		if (batch.size() > 0) batch[batch.size()-1].last = 1;
		foreach (batch[i]) board.note(batch[i]);
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// output sampling and receiver stalls
	always @(posedge clk) begin
		update_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser; got.slot = m_tdata[2:0];
			got.value = m_tdata[12:3]; got.last = m_tlast;
			board.check(got);
		end
	end

	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 0;
		end else
			m_tready <= busy_out ? ($urandom_range(99) >= 17) : 1'b1;
	end

	// leaves the word offered; the next call or drain() takes it down
	task automatic send_word(opcode_t op, logic [15:0] a, logic [7:0] d, logic vis);
		while (busy_in && $urandom_range(99) < 17) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= op;
		s_tdata  <= {7'b0, vis, d, a};
		do @(posedge clk); while (!s_tready);
		predict_word(op, a, d, vis);
		n_words++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [8:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PATCH_MODE: m_patch = val[1:0];
			CFG_PRG_BANKS:  m_banks = val;
			default:        m_chr_rom = val[0];
		endcase
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	function automatic logic [15:0] high_addr();
		logic [15:0] hi[8];
		hi = '{HI_BANK_SEL, HI_BANK_DATA, HI_MIRROR, HI_IRQ_LATCH,
			HI_IRQ_RELD, HI_IRQ_OFF, HI_IRQ_ON, 16'h0000};
		if ($urandom_range(19) == 0) return 16'($urandom());
		// random don't-care bits keep the decode the same
		return hi[$urandom_range(6)] | (16'($urandom()) & ~HI_MASK);
	endfunction

	// mostly well-formed mapper traffic
	task automatic random_words(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 3) send_word(OP_RESTART, 16'($urandom()), 8'($urandom()), 1'($urandom()));
			else if (r < 20)
				send_word(OP_LOW, 16'($urandom()),
					($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom()) & 8'hBF, 0);
			else if (r < 75) send_word(OP_HIGH, high_addr(), 8'($urandom()), 1'($urandom()));
			else send_word(OP_TICK, 16'($urandom()), 8'($urandom()), ($urandom_range(3) != 0));
		end
	endtask

	initial begin
		board = new();
		arst_n = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		cycles = 0; n_words = 0; hold_off = 0; busy_out = 0; busy_in = 0;
		m_patch = 0; m_banks = 64; m_chr_rom = 1;
		power_on();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: restart, every high decode, irq path
		send_word(OP_RESTART, 16'h0000, 8'h00, 0);
		send_word(OP_LOW, 16'h6000, 8'hFF, 0);
		send_word(OP_LOW, 16'h6000, 8'h3F, 0);
		send_word(OP_LOW, 16'h6000, 8'h8F, 0);
		send_word(OP_LOW, 16'h6000, 8'h00, 0);
		send_word(OP_HIGH, HI_BANK_SEL, 8'hC6, 0);
		send_word(OP_HIGH, HI_BANK_DATA, 8'hFF, 0);
		send_word(OP_HIGH, HI_BANK_SEL, 8'h07, 0);
		send_word(OP_HIGH, HI_BANK_DATA, 8'h80, 0);
		send_word(OP_HIGH, HI_MIRROR, 8'h01, 0);
		send_word(OP_HIGH, 16'hFFFE, 8'h55, 0);
		send_word(OP_HIGH, HI_IRQ_OFF, 8'h00, 0);
		send_word(OP_HIGH, HI_IRQ_LATCH, 8'h02, 0);
		send_word(OP_HIGH, HI_IRQ_ON, 8'h00, 0);
		send_word(OP_TICK, 16'h0000, 8'h00, 0);
		send_word(OP_TICK, 16'h0000, 8'h00, 1);
		send_word(OP_TICK, 16'hFFFF, 8'hFF, 1);
		send_word(OP_HIGH, HI_IRQ_RELD, 8'h00, 0);
		send_word(OP_LOW, 16'h0000, 8'h40, 0);
		send_word(OP_LOW, 16'h0000, 8'h12, 0);     // lock bit still clear: written to outer register 1
		send_word(OP_RESTART, 16'hFFFF, 8'hFF, 1);

		// long receiver hold-off while words keep coming
		drain();
		hold_off = 300;
		random_words(15);
		drain();

		// settings sweep including the extremes
		busy_in = 1; busy_out = 1;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_reg(CFG_PATCH_MODE, 1); write_reg(CFG_PRG_BANKS, 256);
					write_reg(CFG_CHR_ROM, 0); end
				1: begin write_reg(CFG_PATCH_MODE, 2); write_reg(CFG_PRG_BANKS, 2);
					write_reg(CFG_CHR_ROM, 1); end
				2: begin write_reg(CFG_PATCH_MODE, 3); write_reg(CFG_PRG_BANKS, 511); end
				3: begin write_reg(CFG_PATCH_MODE, 0); write_reg(CFG_PRG_BANKS, 0); end
				default: begin write_reg(CFG_PATCH_MODE, 2); write_reg(CFG_PRG_BANKS, 128); end
			endcase
			send_word(OP_RESTART, 0, 0, 0);
			if (ph == 1) begin
				send_word(OP_HIGH, HI_IRQ_LATCH, IRQ_ODD_A, 0);
				send_word(OP_HIGH, HI_IRQ_LATCH, IRQ_ODD_B, 0);
			end
			random_words(ph == 4 ? 110 : 30);
			drain();
		end

		$display("Covered %0d input words, %0d updates checked, over five register settings",
			n_words, board.n_seen);
		if (board.n_bad == 0 && board.pending.size() == 0)
			$display("Simulation PASSED");
		else begin
			$display("Mismatches: %0d, left over: %0d", board.n_bad, board.pending.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== multicart_bank_and_scanline_irq_mapper.f =====
rtl/mcm_pkg.sv
rtl/mcm_ctrl.sv
rtl/mcm_datapath.sv
rtl/multicart_bank_and_scanline_irq_mapper.sv
rtl/mcm_checker.sv
sim/tb_top.sv
